@@ rtl/tcpop_pkg.sv @@
// Shared types and constants for the TCP option parser.
package tcpop_pkg;

	// Option kinds
	localparam logic [7:0] KIND_EOL   = 8'd0;
	localparam logic [7:0] KIND_NOP   = 8'd1;
	localparam logic [7:0] KIND_MSS   = 8'd2;
	localparam logic [7:0] KIND_WS    = 8'd3;
	localparam logic [7:0] KIND_SACKP = 8'd4;
	localparam logic [7:0] KIND_SACK  = 8'd5;
	localparam logic [7:0] KIND_TS    = 8'd8;
	localparam logic [7:0] KIND_MPTCP = 8'd30;

	// Smallest legal length byte (kind and length bytes themselves)
	localparam logic [7:0] MIN_OPT_LEN = 8'd2;

	// Body position counter saturates here
	localparam logic [3:0] POS_MAX = 4'd15;

	// Width of the result tdata bus
	localparam int OUT_W = 96;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_KIND = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	// Accumulated option flags
	typedef struct packed {
		logic bad;
		logic mp;
		logic ts;
		logic sack;
		logic sackp;
		logic ws;
		logic mss;
	} flags_t;

	// Summary result; first member is the top bit, so the layout
	// matches tdata with mss_found in bit 0.
	typedef struct packed {
		logic        pad;
		logic        malformed;
		logic        mptcp_seen;
		logic [31:0] ts_echo;
		logic [31:0] ts_value;
		logic        ts_found;
		logic        sack_seen;
		logic        sack_permitted;
		logic [7:0]  wscale_value;
		logic        wscale_found;
		logic [15:0] mss_value;
		logic        mss_found;
	} res_t;

endpackage

@@ rtl/tcpop_core.sv @@
// Option walker: per-byte state update and summary for the final byte.
module tcpop_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,       // process one byte this cycle
	input  logic [7:0]    opt_byte,
	input  logic          last_byte,
	output tcpop_pkg::res_t res       // summary, valid when step && last_byte
);
	import tcpop_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  left_q, left_d;
	logic [3:0]  pos_q, pos_d;
	logic [63:0] vs_q, vs_d;
	logic        stop_q, stop_d;
	flags_t      flg_q, flg_d;
	logic [15:0] mss_q, mss_d;
	logic [7:0]  ws_q, ws_d;
	logic        fin;
	logic        bad_f;

	// Next state for one option byte
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		left_d  = left_q;
		pos_d   = pos_q;
		vs_d    = vs_q;
		stop_d  = stop_q;
		flg_d   = flg_q;
		mss_d   = mss_q;
		ws_d    = ws_q;
		fin     = 1'b0;
		if (!stop_q) begin
			case (phase_q)
				PH_KIND: begin
					if (opt_byte == KIND_EOL) begin
						stop_d = 1'b1;
					end else if (opt_byte != KIND_NOP) begin
						kind_d  = opt_byte;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (opt_byte < MIN_OPT_LEN) begin
						flg_d.bad = 1'b1;
						stop_d    = 1'b1;
						phase_d   = PH_KIND;
					end else begin
						left_d = opt_byte - MIN_OPT_LEN;
						pos_d  = 4'd0;
						if (kind_q == KIND_MSS) begin
							mss_d = 16'd0;
						end else if (kind_q == KIND_WS) begin
							ws_d = 8'd0;
						end else if (kind_q == KIND_TS) begin
							vs_d = 64'd0;
						end
						if (left_d == 8'd0) begin
							fin = 1'b1;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					// capture body bytes by position
					if (kind_q == KIND_MSS) begin
						if (pos_q == 4'd0) begin
							mss_d[15:8] = opt_byte;
						end else if (pos_q == 4'd1) begin
							mss_d[7:0] = opt_byte;
						end
					end else if (kind_q == KIND_WS) begin
						if (pos_q == 4'd0) begin
							ws_d = opt_byte;
						end
					end else if (kind_q == KIND_TS) begin
						if (!pos_q[3]) begin
							vs_d[{~pos_q[2:0], 3'b000} +: 8] = opt_byte;
						end
					end
					if (pos_q != POS_MAX) begin
						pos_d = pos_q + 4'd1;
					end
					left_d = left_q - 8'd1;
					if (left_d == 8'd0) begin
						fin = 1'b1;
					end
				end
				default: ;
			endcase
		end
		// option complete: mark its kind
		if (fin) begin
			case (kind_q)
				KIND_MSS:   flg_d.mss   = 1'b1;
				KIND_WS:    flg_d.ws    = 1'b1;
				KIND_SACKP: flg_d.sackp = 1'b1;
				KIND_SACK:  flg_d.sack  = 1'b1;
				KIND_TS:    flg_d.ts    = 1'b1;
				KIND_MPTCP: flg_d.mp    = 1'b1;
				default: ;
			endcase
			phase_d = PH_KIND;
		end
	end

	// Summary: an option still open at the end counts as cut off
	assign bad_f = flg_d.bad | (!stop_d && (phase_d != PH_KIND));

	always_comb begin
		res                = '0;
		res.mss_found      = flg_d.mss;
		res.mss_value      = flg_d.mss ? mss_d : 16'd0;
		res.wscale_found   = flg_d.ws;
		res.wscale_value   = flg_d.ws ? ws_d : 8'd0;
		res.sack_permitted = flg_d.sackp;
		res.sack_seen      = flg_d.sack;
		res.ts_found       = flg_d.ts;
		res.ts_value       = flg_d.ts ? vs_d[63:32] : 32'd0;
		res.ts_echo        = flg_d.ts ? vs_d[31:0] : 32'd0;
		res.mptcp_seen     = flg_d.mp;
		res.malformed      = bad_f;
	end

	// State registers; the final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KIND;
			kind_q  <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			vs_q    <= '0;
			stop_q  <= 1'b0;
			flg_q   <= '0;
			mss_q   <= '0;
			ws_q    <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= PH_KIND;
				kind_q  <= '0;
				left_q  <= '0;
				pos_q   <= '0;
				vs_q    <= '0;
				stop_q  <= 1'b0;
				flg_q   <= '0;
				mss_q   <= '0;
				ws_q    <= '0;
			end else begin
				phase_q <= phase_d;
				kind_q  <= kind_d;
				left_q  <= left_d;
				pos_q   <= pos_d;
				vs_q    <= vs_d;
				stop_q  <= stop_d;
				flg_q   <= flg_d;
				mss_q   <= mss_d;
				ws_q    <= ws_d;
			end
		end
	end

	// After the final byte the walker is back at its start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> phase_q == PH_KIND && !stop_q && flg_q == '0)
		else $error("parser not restarted after final byte");

	// Once stopped, no option is open
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> phase_q == PH_KIND)
		else $error("stopped with an option open");

	// Body phase always has bytes outstanding
	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != 8'd0)
		else $error("body phase with no bytes left");

endmodule

@@ rtl/tcpop_out_reg.sv @@
// Result register for the summary stream.
module tcpop_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  tcpop_pkg::res_t                res,
	output logic                           tvalid,
	input  logic                           tready,
	output logic [tcpop_pkg::OUT_W-1:0]    tdata
);
	import tcpop_pkg::*;

	res_t res_q;
	logic vld_q;

	// Valid flag: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (tready) begin
			vld_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign tvalid = vld_q;
	assign tdata  = res_q;

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !vld_q || tready)
		else $error("result overwritten while stalled");

endmodule

@@ rtl/tcp_option_parser.sv @@
// Top level of the TCP option parser.
//
// Input stream (s_axis_*): one byte of the TCP option area per item, in
// header order; tlast marks the final byte of the area. Output stream
// (m_axis_*): one summary item per option area, sent for the byte with
// tlast. Bytes without tlast give no output.
// Path: the final byte passes from the input register through the walker
// logic into the result register, which drives m_axis; the final byte moves
// on as soon as the result register is free.
// Throughput: one byte per cycle, sustained while no final byte waits on a
// busy result register; a new area may follow the previous one with no gap.
// Stall: while a summary waits on m_axis_tready, non-final bytes keep
// flowing; a final byte holds in the input register until the result
// register frees, and s_axis_tready drops only then.
// Reset: arst_n clears the walker to the start of an option area and
// empties both registers; no reset sweep is needed.
module tcp_option_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] opt_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] mss_found, [16:1] mss_value, [17] wscale_found, [25:18] wscale_value,
	// [26] sack_permitted, [27] sack_seen, [28] ts_found, [60:29] ts_value,
	// [92:61] ts_echo, [93] mptcp_seen, [94] malformed, [95] zero
	output logic [tcpop_pkg::OUT_W-1:0] m_axis_tdata
);
	import tcpop_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       accept;
	logic       adv;
	logic       out_free;
	logic       out_load;
	res_t       res;

	// Stage 1 moves on unless it carries a final byte and the result is blocked
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv           = vld_s1 && (!last_s1 || out_free);
	assign out_load      = adv && last_s1;
	assign s_axis_tready = !vld_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	tcpop_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.opt_byte  (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	tcpop_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res    (res),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata)
	);

	// Results come only from final bytes
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> vld_s1 && last_s1)
		else $error("result loaded from a non-final byte");

	// An empty input stage always takes a byte
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_axis_tready)
		else $error("input stalled while empty");

	// A held final byte is released as soon as the result register frees
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && last_s1 && out_free |=> $past(out_load))
		else $error("final byte not released");

	// Pad bit of the result is always zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1] == 1'b0)
		else $error("pad bit set");

endmodule
